@@ src/bole_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded ordered list engine package
// Operation codes and sequencer states shared by the list engine files.
// ----------------------------------------------------------------------------
package bole_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned FIELD_W = 5;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_SORTED_INS = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4,
      OP_REMOVE     = 3'd5,
      OP_READ       = 3'd6,
      OP_FIND       = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_UP_RD,
      ST_UP_WR,
      ST_DN_RD,
      ST_DN_WR,
      ST_READ_WAIT
   } state_type;

   // response strobe flag, raised for the single cycle a result is shown
   typedef enum logic {
      RSP_OFF,
      RSP_ON
   } rsp_type;

endpackage

@@ src/bole_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bole_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/bounded_ordered_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Sequencing: a scan reads and compares each entry visited and a shift
//   reads and writes each entry moved; the longest requests are a sorted
//   insert or remove that walks the whole list.
// Throughput: one request in flight; start is taken again the cycle after
//   the rsp_valid strobe. All entry traffic runs through one RAM read port.
// Reset: synchronous; clears the entry count and the sequencer, RAM untouched.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top
   import bole_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_value,
   input  logic [4:0]  req_position,
   // response channel
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [31:0] rsp_read_value,
   output logic [4:0]  rsp_found_position,
   output logic [4:0]  rsp_entry_count,
   output logic        rsp_is_empty
);

   // LW holds a count up to CAPACITY, IW indexes one entry,
   // CW is wide enough to compare a count against the 5-bit position.
   localparam int unsigned LW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned CW = (LW > FIELD_W) ? LW : FIELD_W;

   state_type            state_ff, state_in;
   rsp_type              rsp_ff, rsp_in;
   op_type               op_ff, op_in;
   logic [DATA_W-1:0]    val_ff, val_in;
   logic [LW-1:0]        len_ff, len_in;
   logic [LW-1:0]        idx_ff, idx_in;
   logic [LW-1:0]        at_ff, at_in;
   logic                 ok_ff, ok_in;
   logic [DATA_W-1:0]    rd_ff, rd_in;
   logic [FIELD_W-1:0]   fp_ff, fp_in;

   logic                 ram_we;
   logic [IW-1:0]        ram_waddr;
   logic [DATA_W-1:0]    ram_wdata;
   logic [IW-1:0]        ram_raddr;
   logic [DATA_W-1:0]    ram_rdata;

   logic                 accept;
   op_type               req_op;
   logic                 full;
   logic                 empty;
   logic                 pos_ok;
   logic [CW-1:0]        pos_ext;
   logic [CW-1:0]        len_ext;
   logic [CW-1:0]        pos_m1;
   logic                 scan_more;
   logic                 hit;
   logic                 up_more;
   logic                 dn_more;
   logic [LW-1:0]        idx_p1;
   logic [LW-1:0]        idx_m1;
   logic [LW+FIELD_W-1:0] fp_ext;
   logic [LW+FIELD_W-1:0] cnt_ext;

   bole_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy   = (state_ff != ST_IDLE) || (rsp_ff == RSP_ON);
   assign accept = start && !busy;
   assign req_op = op_type'(req_operation);

   assign full    = (len_ff == LW'(CAPACITY));
   assign empty   = (len_ff == '0);
   assign pos_ext = CW'(req_position);
   assign len_ext = CW'(len_ff);
   assign pos_m1  = pos_ext - CW'(1);
   assign pos_ok  = (pos_ext != '0) && (pos_ext <= len_ext);

   assign idx_p1    = idx_ff + LW'(1);
   assign idx_m1    = idx_ff - LW'(1);
   assign scan_more = (idx_ff < len_ff);
   assign up_more   = (idx_ff > at_ff);
   assign dn_more   = (idx_p1 < len_ff);

   // Shared compare unit: one registered RAM word against the request value.
   // Sorted insert stops before the head only if the head is greater,
   // later it stops at the first entry that is not less than the value.
   always_comb begin
      if (op_ff == OP_SORTED_INS) begin
         if (idx_ff == '0) begin
            hit = $signed(val_ff) < $signed(ram_rdata);
         end else begin
            hit = !($signed(ram_rdata) < $signed(val_ff));
         end
      end else begin
         hit = (ram_rdata == val_ff);
      end
   end

   assign fp_ext  = {{FIELD_W{1'b0}}, idx_p1};
   assign cnt_ext = {{FIELD_W{1'b0}}, len_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      rsp_in   = RSP_OFF;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (full) rsp_in = RSP_ON;
                     else      state_in = ST_UP_RD;
                  end
                  OP_SORTED_INS: begin
                     if (full) rsp_in = RSP_ON;
                     else      state_in = ST_SCAN_RD;
                  end
                  OP_POP_FRONT: begin
                     if (empty) rsp_in = RSP_ON;
                     else       state_in = ST_DN_RD;
                  end
                  OP_POP_BACK: begin
                     rsp_in = RSP_ON;
                  end
                  OP_REMOVE, OP_FIND: begin
                     state_in = ST_SCAN_RD;
                  end
                  OP_READ: begin
                     if (pos_ok) state_in = ST_READ_WAIT;
                     else        rsp_in   = RSP_ON;
                  end
                  default: begin
                     rsp_in = RSP_ON;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (scan_more) begin
               state_in = ST_SCAN_CMP;
            end else if (op_ff == OP_SORTED_INS) begin
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_IDLE;
               rsp_in   = RSP_ON;
            end
         end
         ST_SCAN_CMP: begin
            if (!hit) begin
               state_in = ST_SCAN_RD;
            end else begin
               unique case (op_ff)
                  OP_SORTED_INS: state_in = ST_UP_RD;
                  OP_REMOVE:     state_in = ST_DN_RD;
                  default: begin
                     state_in = ST_IDLE;
                     rsp_in   = RSP_ON;
                  end
               endcase
            end
         end
         ST_UP_RD: begin
            if (up_more) begin
               state_in = ST_UP_WR;
            end else begin
               state_in = ST_IDLE;
               rsp_in   = RSP_ON;
            end
         end
         ST_UP_WR: state_in = ST_UP_RD;
         ST_DN_RD: begin
            if (dn_more) begin
               state_in = ST_DN_WR;
            end else begin
               state_in = ST_IDLE;
               rsp_in   = RSP_ON;
            end
         end
         ST_DN_WR: state_in = ST_DN_RD;
         ST_READ_WAIT: begin
            state_in = ST_IDLE;
            rsp_in   = RSP_ON;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and RAM control
   always_comb begin
      op_in     = op_ff;
      val_in    = val_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      at_in     = at_ff;
      ok_in     = ok_ff;
      rd_in     = rd_ff;
      fp_in     = fp_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff[IW-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = idx_ff[IW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = pos_m1[IW-1:0];
            if (accept) begin
               op_in  = req_op;
               val_in = req_value;
               ok_in  = 1'b0;
               rd_in  = '0;
               fp_in  = '0;
               idx_in = '0;
               at_in  = '0;
               unique case (req_op)
                  OP_PUSH_FRONT: idx_in = len_ff;
                  OP_PUSH_BACK: begin
                     idx_in = len_ff;
                     at_in  = len_ff;
                  end
                  OP_POP_BACK: begin
                     // drop the tail by shortening the count
                     if (!empty) begin
                        len_in = len_ff - LW'(1);
                        ok_in  = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            ram_raddr = idx_ff[IW-1:0];
            if (!scan_more && op_ff == OP_SORTED_INS) begin
               at_in = len_ff;
            end
         end
         ST_SCAN_CMP: begin
            if (!hit) begin
               idx_in = idx_p1;
            end else begin
               unique case (op_ff)
                  OP_SORTED_INS: begin
                     at_in  = idx_ff;
                     idx_in = len_ff;
                  end
                  OP_REMOVE: begin
                  end
                  default: begin
                     ok_in = 1'b1;
                     fp_in = fp_ext[FIELD_W-1:0];
                  end
               endcase
            end
         end
         ST_UP_RD: begin
            ram_raddr = idx_m1[IW-1:0];
            if (!up_more) begin
               // slot is open: drop the new value in and grow the list
               ram_we    = 1'b1;
               ram_waddr = at_ff[IW-1:0];
               ram_wdata = val_ff;
               len_in    = len_ff + LW'(1);
               ok_in     = 1'b1;
            end
         end
         ST_UP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[IW-1:0];
            idx_in    = idx_m1;
         end
         ST_DN_RD: begin
            ram_raddr = idx_p1[IW-1:0];
            if (!dn_more) begin
               len_in = len_ff - LW'(1);
               ok_in  = 1'b1;
            end
         end
         ST_DN_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[IW-1:0];
            idx_in    = idx_p1;
         end
         ST_READ_WAIT: begin
            rd_in = ram_rdata;
            ok_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_ff   <= RSP_OFF;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      at_ff  <= at_in;
      ok_ff  <= ok_in;
      rd_ff  <= rd_in;
      fp_ff  <= fp_in;
   end

   // Response is shown for one cycle; the count wraps modulo 32 on big lists
   assign rsp_valid          = (rsp_ff == RSP_ON);
   assign rsp_ok             = ok_ff;
   assign rsp_read_value     = rd_ff;
   assign rsp_found_position = fp_ff;
   assign rsp_entry_count    = cnt_ext[FIELD_W-1:0];
   assign rsp_is_empty       = empty;

endmodule

@@ src/bole_chk.sv @@
// ----------------------------------------------------------------------------
// Bounded ordered list engine port checker
// Watches the top-level ports and flags handshake or result slips.
// ----------------------------------------------------------------------------
module bole_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_ok,
   input logic [31:0] rsp_read_value,
   input logic [4:0]  rsp_found_position,
   input logic [4:0]  rsp_entry_count,
   input logic        rsp_is_empty
);

   // an accepted request keeps the engine busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("engine not busy after accepting a request");

   // the strobe lasts exactly one cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   // a response only appears while a request is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while idle");

   // failed operations carry zero payload
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_read_value == 32'd0 && rsp_found_position == 5'd0)
      else $error("failed operation returned a nonzero payload");

   // an empty list reports a zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_entry_count == 5'd0)
      else $error("empty flag with nonzero count");

endmodule

bind bounded_ordered_list_engine_top bole_chk u_bole_chk (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_ok             (rsp_ok),
   .rsp_read_value     (rsp_read_value),
   .rsp_found_position (rsp_found_position),
   .rsp_entry_count    (rsp_entry_count),
   .rsp_is_empty       (rsp_is_empty)
);

@@ tb/sv/bounded_ordered_list_engine_top_tb.sv @@
// ----------------------------------------------------------------------------
// Bounded ordered list engine testbench
// Drives list requests through the start/busy handshake and keeps a shadow
// copy of the list to predict every response. A checker compares each
// rsp_valid strobe field by field against the oldest predicted response.
// Directed tests cover the empty and full list, the value extremes and every
// operation. A long random run then moves the list between empty and full.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top_tb;
   import bole_pkg::*;

   localparam int unsigned CAPACITY   = 16;
   localparam int          CLK_PERIOD = 12;
   localparam int          RESET_CYC  = 7;
   // worst case of one request: walk and shift of the whole list
   localparam int          WORST_LAT  = 2 * CAPACITY + 3;
   localparam int          RAND_ITEMS = 800;

   typedef struct packed {
      logic        ok;
      logic [31:0] read_value;
      logic [4:0]  found_position;
      logic [4:0]  entry_count;
      logic        is_empty;
   } list_rsp_type;

   // DUT ports; the driven inputs are known from time zero
   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        start              = 1'b0;
   logic        busy;
   logic [2:0]  req_operation      = OP_PUSH_FRONT;
   logic [31:0] req_value          = '0;
   logic [4:0]  req_position       = '0;
   logic        rsp_valid;
   logic        rsp_ok;
   logic [31:0] rsp_read_value;
   logic [4:0]  rsp_found_position;
   logic [4:0]  rsp_entry_count;
   logic        rsp_is_empty;

   // shadow list, head at index 0
   logic signed [31:0] shadow_list[$];
   // predicted responses, oldest first
   list_rsp_type       pending_rsp[$];

   int  error_count;
   int  op_count[8];
   int  full_rejects;
   int  empty_rejects;
   int  max_depth;
   bit  burst_mode;

   bounded_ordered_list_engine_top #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_value          (req_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_is_empty       (rsp_is_empty)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Shadow list predictor
   // ------------------------------------------------------------------------

   // Return the index of the first entry equal to val, or -1.
   function automatic int locate_value(logic signed [31:0] val);
      foreach (shadow_list[k]) begin
         if (shadow_list[k] == val) return k;
      end
      return -1;
   endfunction

   // Apply one request to the shadow list and return the response it causes.
   function automatic list_rsp_type apply_list_op(op_type op, logic signed [31:0] val,
                                                  logic [4:0] pos);
      list_rsp_type r;
      int           idx;
      bit           full;
      r    = '0;
      full = shadow_list.size() >= CAPACITY;
      case (op)
         OP_PUSH_FRONT: begin
            if (!full) begin
               shadow_list.push_front(val);
               r.ok = 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (!full) begin
               shadow_list.push_back(val);
               r.ok = 1'b1;
            end
         end
         OP_SORTED_INS: begin
            if (!full) begin
               // a value below the head goes to the front, exactly once
               if (shadow_list.size() == 0 || val < shadow_list[0]) begin
                  shadow_list.push_front(val);
               end else begin
                  // the head is never compared again: scan from the second entry
                  idx = 1;
                  while (idx < shadow_list.size() && shadow_list[idx] < val) idx++;
                  shadow_list.insert(idx, val);
               end
               r.ok = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (shadow_list.size() > 0) begin
               void'(shadow_list.pop_front());
               r.ok = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (shadow_list.size() > 0) begin
               void'(shadow_list.pop_back());
               r.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            idx = locate_value(val);
            if (idx >= 0) begin
               shadow_list.delete(idx);
               r.ok = 1'b1;
            end
         end
         OP_READ: begin
            if (pos >= 1 && pos <= shadow_list.size()) begin
               r.read_value = shadow_list[pos - 1];
               r.ok         = 1'b1;
            end
         end
         default: begin
            idx = locate_value(val);
            if (idx >= 0) begin
               r.found_position = 5'(idx + 1);
               r.ok             = 1'b1;
            end
         end
      endcase
      r.entry_count = 5'(shadow_list.size());
      r.is_empty    = (shadow_list.size() == 0);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------

   // Send one request. Hold start high across back-to-back requests so it is
   // never dropped and raised in the same step; lower it only for a gap.
   task automatic send_request(input op_type op, input logic signed [31:0] val,
                               input logic [4:0] pos);
      int           gap;
      list_rsp_type exp_rsp;
      gap = burst_mode ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_value     <= val;
      req_position  <= pos;
      // accepted at the first edge that samples busy low
      do @(posedge clock); while (busy !== 1'b0);
      exp_rsp = apply_list_op(op, val, pos);
      pending_rsp.push_back(exp_rsp);
      op_count[op]++;
      if (!exp_rsp.ok && op inside {OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED_INS})
         full_rejects++;
      if (!exp_rsp.ok && op inside {OP_POP_FRONT, OP_POP_BACK, OP_REMOVE} &&
          shadow_list.size() == 0)
         empty_rejects++;
      if (shadow_list.size() > max_depth) max_depth = shadow_list.size();
   endtask

   // Drop start and hold off until every predicted response has arrived.
   task automatic drain_responses();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Pick a value: extremes, a small cluster that repeats, a live entry, or
   // anything at all.
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'sh8000_0000;
      if (r == 1) return 32'sh7fff_ffff;
      if (r <= 5) return $signed($urandom_range(0, 15)) - 8;
      if (r <= 7 && shadow_list.size() > 0)
         return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
      return $signed($urandom());
   endfunction

   // ------------------------------------------------------------------------
   // Response checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      list_rsp_type exp_rsp;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with none expected", $time);
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_ok !== exp_rsp.ok) begin
               $display("%0t: ok expected %0b actual %0b", $time, exp_rsp.ok, rsp_ok);
               error_count++;
            end
            if (rsp_read_value !== exp_rsp.read_value) begin
               $display("%0t: read_value expected %0d actual %0d", $time,
                        $signed(exp_rsp.read_value), $signed(rsp_read_value));
               error_count++;
            end
            if (rsp_found_position !== exp_rsp.found_position) begin
               $display("%0t: found_position expected %0d actual %0d", $time,
                        exp_rsp.found_position, rsp_found_position);
               error_count++;
            end
            if (rsp_entry_count !== exp_rsp.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d", $time,
                        exp_rsp.entry_count, rsp_entry_count);
               error_count++;
            end
            if (rsp_is_empty !== exp_rsp.is_empty) begin
               $display("%0t: is_empty expected %0b actual %0b", $time,
                        exp_rsp.is_empty, rsp_is_empty);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Every removal and query on an empty list must fail and leave it empty.
   task automatic test_empty_list();
      send_request(OP_POP_FRONT, 0, 0);
      send_request(OP_POP_BACK, 0, 0);
      send_request(OP_REMOVE, 0, 0);
      send_request(OP_FIND, 0, 0);
      send_request(OP_READ, 0, 5'd1);
   endtask

   // Value extremes, sorted placement, present and absent lookups, reads at
   // every boundary position.
   task automatic test_extremes();
      send_request(OP_SORTED_INS, 0, 0);               // into an empty list
      send_request(OP_SORTED_INS, 32'sh8000_0000, 0);  // below the head
      send_request(OP_SORTED_INS, 32'sh7fff_ffff, 0);  // walks to the tail
      send_request(OP_SORTED_INS, 32'sh8000_0000, 0);  // equal to the head
      send_request(OP_PUSH_FRONT, -1, 0);
      send_request(OP_PUSH_BACK, 5, 0);
      send_request(OP_SORTED_INS, 3, 0);               // after a front and a back push
      send_request(OP_FIND, 32'sh7fff_ffff, 0);
      send_request(OP_FIND, 123, 0);
      send_request(OP_REMOVE, 123, 0);
      send_request(OP_REMOVE, 32'sh7fff_ffff, 0);
      send_request(OP_READ, 0, 5'd0);
      send_request(OP_READ, 0, 5'd1);
      send_request(OP_READ, 0, 5'(shadow_list.size()));
      send_request(OP_READ, 0, 5'(shadow_list.size() + 1));
      send_request(OP_READ, 0, 5'd31);
      send_request(OP_POP_FRONT, 0, 0);
      send_request(OP_POP_BACK, 0, 0);
   endtask

   // Fill to capacity, reject every insert kind, then empty by pops and
   // removes and underflow once more.
   task automatic test_capacity();
      while (shadow_list.size() < CAPACITY)
         send_request(op_type'($urandom_range(0, 2)), pick_value(), 0);
      send_request(OP_PUSH_FRONT, 1, 0);
      send_request(OP_PUSH_BACK, 2, 0);
      send_request(OP_SORTED_INS, 3, 0);
      send_request(OP_READ, 0, 5'(CAPACITY));
      send_request(OP_FIND, shadow_list[CAPACITY - 1], 0);
      while (shadow_list.size() > 0) begin
         if ($urandom_range(0, 2) == 0)
            send_request(OP_REMOVE, shadow_list[$urandom_range(0, shadow_list.size() - 1)], 0);
         else
            send_request(op_type'($urandom_range(3, 4)), 0, 0);
      end
      send_request(OP_POP_FRONT, 0, 0);
   endtask

   // Random traffic that swings between growing and shrinking the list, with
   // a little noise and runs of back-to-back requests.
   task automatic test_random_traffic(input int n_items);
      bit                 grow;
      int                 r;
      op_type             op;
      logic signed [31:0] val;
      logic [4:0]         pos;
      grow = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         if (shadow_list.size() == CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
         if (shadow_list.size() == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
         if ($urandom_range(0, 59) == 0) grow = ~grow;
         val = pick_value();
         pos = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, shadow_list.size() + 1));
         r = $urandom_range(0, 99);
         if (r < 8) begin
            // noise: anything at all
            op  = op_type'($urandom_range(0, 7));
            val = $signed($urandom());
            pos = 5'($urandom_range(0, 31));
         end else if (r < (grow ? 60 : 25)) begin
            op = op_type'($urandom_range(0, 2));
         end else if (r < (grow ? 75 : 70)) begin
            op = op_type'($urandom_range(3, 5));
         end else begin
            op = op_type'($urandom_range(6, 7));
         end
         send_request(op, val, pos);
         if (i == n_items / 2) drain_responses();
      end
      burst_mode = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      error_count   = 0;
      full_rejects  = 0;
      empty_rejects = 0;
      max_depth     = 0;
      burst_mode    = 1'b0;
      foreach (op_count[k]) op_count[k] = 0;

      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      drain_responses();
      test_extremes();
      drain_responses();
      test_capacity();
      drain_responses();
      test_random_traffic(RAND_ITEMS);
      drain_responses();

      // let any late strobe show up before the verdict
      repeat (WORST_LAT + 8) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
         error_count++;
      end

      $display("Requests by operation: pushf %0d pushb %0d sorted %0d popf %0d popb %0d",
               op_count[OP_PUSH_FRONT], op_count[OP_PUSH_BACK], op_count[OP_SORTED_INS],
               op_count[OP_POP_FRONT], op_count[OP_POP_BACK]);
      $display("  remove %0d read %0d find %0d; full rejects %0d, empty rejects %0d, depth %0d",
               op_count[OP_REMOVE], op_count[OP_READ], op_count[OP_FIND],
               full_rejects, empty_rejects, max_depth);
      if (error_count == 0) begin
         $display("bounded_ordered_list_engine_top: match");
      end else begin
         $display("bounded_ordered_list_engine_top: mismatch");
      end
      $finish;
   end

   // Stop a hung run well past the slowest legal one.
   initial begin
      #(CLK_PERIOD * 400000);
      $display("bounded_ordered_list_engine_top: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
src/bole_pkg.sv
src/bole_ram.sv
src/bounded_ordered_list_engine_top.sv
src/bole_chk.sv
tb/sv/bounded_ordered_list_engine_top_tb.sv
